// ----- hdl/ilp_pkg.sv -----
// Shared constants, type codes and decode functions for the integer literal parser.
package ilp_pkg;

    // Number base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    // Result type codes
    localparam logic [2:0] TYPE_I8  = 3'd0;
    localparam logic [2:0] TYPE_U8  = 3'd1;
    localparam logic [2:0] TYPE_I16 = 3'd2;
    localparam logic [2:0] TYPE_U16 = 3'd3;
    localparam logic [2:0] TYPE_I32 = 3'd4;
    localparam logic [2:0] TYPE_U32 = 3'd5;
    localparam logic [2:0] TYPE_I64 = 3'd6;
    localparam logic [2:0] TYPE_U64 = 3'd7;

    // Digit limits per base
    localparam int unsigned MaxHexDigits = 16;
    localparam int unsigned MaxBinDigits = 64;
    localparam int unsigned MaxDecDigits = 20;
    localparam int unsigned CountWidth   = 7;

    // Character codes
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";
    localparam logic [7:0] CH_LB    = "b";
    localparam logic [7:0] CH_UB    = "B";

    // Lowercased suffix strings, last character in the low byte
    localparam logic [23:0] SFX_U   = {16'h0000, 8'("u")};
    localparam logic [23:0] SFX_L   = {16'h0000, 8'("l")};
    localparam logic [23:0] SFX_I8  = {8'h00, 16'("i8")};
    localparam logic [23:0] SFX_U8  = {8'h00, 16'("u8")};
    localparam logic [23:0] SFX_UL  = {8'h00, 16'("ul")};
    localparam logic [23:0] SFX_I16 = "i16";
    localparam logic [23:0] SFX_U16 = "u16";
    localparam logic [23:0] SFX_I32 = "i32";
    localparam logic [23:0] SFX_U32 = "u32";
    localparam logic [23:0] SFX_I64 = "i64";
    localparam logic [23:0] SFX_U64 = "u64";

    // Digit decode: {valid, value}
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (base == BASE_BIN) begin
            if (c == CH_0 || c == CH_1) begin
                ok = 1'b1;
                v  = c - CH_0;
            end
        end else if (c >= CH_0 && c <= CH_9) begin
            ok = 1'b1;
            v  = c - CH_0;
        end else if (base == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
            ok = 1'b1;
            v  = c - CH_LA + 8'd10;
        end else if (base == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
            ok = 1'b1;
            v  = c - CH_UA + 8'd10;
        end
        return {ok, v[3:0]};
    endfunction

    // Suffix match: {valid, type code}
    function automatic logic [3:0] suffix_type(input logic [23:0] s, input logic [1:0] len);
        logic [3:0] r;
        r = 4'd0;
        unique case (len)
            2'd1: begin
                priority if (s == SFX_U) r = {1'b1, TYPE_U32};
                else if (s == SFX_L)     r = {1'b1, TYPE_I64};
                else                     r = 4'd0;
            end
            2'd2: begin
                priority if (s == SFX_I8) r = {1'b1, TYPE_I8};
                else if (s == SFX_U8)     r = {1'b1, TYPE_U8};
                else if (s == SFX_UL)     r = {1'b1, TYPE_U64};
                else                      r = 4'd0;
            end
            2'd3: begin
                priority if (s == SFX_I16) r = {1'b1, TYPE_I16};
                else if (s == SFX_U16)     r = {1'b1, TYPE_U16};
                else if (s == SFX_I32)     r = {1'b1, TYPE_I32};
                else if (s == SFX_U32)     r = {1'b1, TYPE_U32};
                else if (s == SFX_I64)     r = {1'b1, TYPE_I64};
                else if (s == SFX_U64)     r = {1'b1, TYPE_U64};
                else                       r = 4'd0;
            end
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/integer_literal_parser.sv -----
// Streaming integer literal parser: characters in, one typed 64-bit value out per literal.
// The parser takes one ASCII character per clock cycle unless stalled, with tlast on the final
// character of each literal; it accepts an optional sign, a 0x/0b prefix, digits and an
// optional type suffix (i8..i64, u8..u64, u, ul, l, any case). The per-character accumulator
// update (a shift-add by the base) is combinational and sets that rate. The result of a
// literal leaves on the master side through the input register, finish register and
// output register; tuser carries the parse status and a failed literal reports type and
// value as zero. Characters keep flowing while a finished result waits on the master side;
// the input stalls only when a final character sits in the input register while the finish
// and output registers are both occupied and m_axis_tready is low.
module integer_literal_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    // parse results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [2:0] type_code, [66:3] literal_bits, [71:67] zero
    output logic        m_axis_tuser    // parse_ok
);

    typedef enum logic [2:0] {
        PH_START,
        PH_NUM,
        PH_ZERO,
        PH_NEED,
        PH_DIG,
        PH_SUF
    } phase_t;

    localparam int unsigned CW = ilp_pkg::CountWidth;
    localparam logic [CW-1:0] CountMax = {CW{1'b1}};

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg,  in_char_next;
    logic       in_last_reg,  in_last_next;
    logic       in_ready, in_proc;

    // Parse state
    phase_t        phase_reg, phase_next;
    logic          neg_reg,   neg_next;
    logic [1:0]    base_reg,  base_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [63:0]   acc_reg,   acc_next;
    logic          err_reg,   err_next;
    logic [23:0]   suf_reg,   suf_next;
    logic [1:0]    slen_reg,  slen_next;

    // Finish register (snapshot of a completed literal)
    logic        fin_valid_reg, fin_valid_next;
    logic        fin_ok_reg,    fin_ok_next;
    logic        fin_neg_reg,   fin_neg_next;
    logic [63:0] fin_acc_reg,   fin_acc_next;
    logic [23:0] fin_suf_reg,   fin_suf_next;
    logic [1:0]  fin_slen_reg,  fin_slen_next;
    logic        fin_ready;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg,    out_ok_next;
    logic [2:0]  out_type_reg,  out_type_next;
    logic [63:0] out_bits_reg,  out_bits_next;
    logic        out_ready;

    // Per-character update terms
    phase_t        p_phase;
    logic          p_neg;
    logic [1:0]    p_base;
    logic [CW-1:0] p_cnt;
    logic [63:0]   p_acc;
    logic          p_err;
    logic [23:0]   p_suf;
    logic [1:0]    p_slen;
    logic          p_done, p_dig, p_sfx;
    logic [4:0]    dinfo;
    logic [CW-1:0] cnt_inc;
    logic [67:0]   dec_sum;
    logic [7:0]    lower_c;

    // Result terms
    logic [3:0]  sfx_hit;
    logic        r_ok;
    logic [2:0]  r_type;
    logic [63:0] r_val;
    logic [63:0] r_bits;

    // Handshake chain
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign fin_ready     = !fin_valid_reg || out_ready;
    assign in_proc       = in_valid_reg && (!in_last_reg || fin_ready);
    assign in_ready      = !in_valid_reg || in_proc;
    assign s_axis_tready = in_ready;

    assign dinfo   = ilp_pkg::digit_of(in_char_reg, base_reg);
    assign lower_c = (in_char_reg >= ilp_pkg::CH_UA && in_char_reg <= ilp_pkg::CH_UZ)
                     ? (in_char_reg | 8'h20) : in_char_reg;

    // Character step
    always_comb begin
        p_phase = phase_reg;
        p_neg   = neg_reg;
        p_base  = base_reg;
        p_cnt   = cnt_reg;
        p_acc   = acc_reg;
        p_err   = err_reg;
        p_suf   = suf_reg;
        p_slen  = slen_reg;
        p_done  = 1'b0;
        p_dig   = 1'b0;
        p_sfx   = 1'b0;
        cnt_inc = '0;
        dec_sum = '0;
        if (!err_reg) begin
            if (p_phase == PH_START) begin
                p_phase = PH_NUM;
                if ((in_char_reg == ilp_pkg::CH_PLUS || in_char_reg == ilp_pkg::CH_MINUS)
                    && !in_last_reg) begin
                    p_neg  = (in_char_reg == ilp_pkg::CH_MINUS);
                    p_done = 1'b1;
                end
            end
            // first digit (base is decimal here)
            if (!p_done && p_phase == PH_NUM) begin
                p_done = 1'b1;
                if (dinfo[4]) begin
                    p_dig   = 1'b1;
                    p_phase = (in_char_reg == ilp_pkg::CH_0) ? PH_ZERO : PH_DIG;
                end else begin
                    p_err = 1'b1;
                end
            end
            // prefix check after a leading zero
            if (!p_done && p_phase == PH_ZERO) begin
                if (in_char_reg == ilp_pkg::CH_LX || in_char_reg == ilp_pkg::CH_UX ||
                    in_char_reg == ilp_pkg::CH_LB || in_char_reg == ilp_pkg::CH_UB) begin
                    p_base  = (in_char_reg == ilp_pkg::CH_LX || in_char_reg == ilp_pkg::CH_UX)
                              ? ilp_pkg::BASE_HEX : ilp_pkg::BASE_BIN;
                    p_cnt   = '0;
                    p_acc   = '0;
                    p_phase = PH_NEED;
                    p_done  = 1'b1;
                end else begin
                    p_phase = PH_DIG;
                end
            end
            if (!p_done && p_phase == PH_NEED) begin
                p_done = 1'b1;
                if (dinfo[4]) begin
                    p_dig   = 1'b1;
                    p_phase = PH_DIG;
                end else begin
                    p_err = 1'b1;
                end
            end
            if (!p_done && p_phase == PH_DIG) begin
                if (dinfo[4]) begin
                    p_dig  = 1'b1;
                    p_done = 1'b1;
                end else begin
                    p_phase = PH_SUF;
                end
            end
            if (!p_done) begin
                if (p_phase == PH_SUF) p_sfx = 1'b1;
                else                   p_err = 1'b1;
            end
        end

        // accumulate a digit
        if (p_dig) begin
            cnt_inc = (p_cnt != CountMax) ? p_cnt + 1'b1 : p_cnt;
            p_cnt   = cnt_inc;
            dec_sum = ({4'd0, p_acc} << 3) + ({4'd0, p_acc} << 1) + {64'd0, dinfo[3:0]};
            unique case (p_base)
                ilp_pkg::BASE_HEX: begin
                    if (cnt_inc > CW'(ilp_pkg::MaxHexDigits)) p_err = 1'b1;
                    else p_acc = {p_acc[59:0], dinfo[3:0]};
                end
                ilp_pkg::BASE_BIN: begin
                    if (cnt_inc > CW'(ilp_pkg::MaxBinDigits)) p_err = 1'b1;
                    else p_acc = {p_acc[62:0], dinfo[0]};
                end
                default: begin
                    if (cnt_inc > CW'(ilp_pkg::MaxDecDigits) || (|dec_sum[67:64])) p_err = 1'b1;
                    else p_acc = dec_sum[63:0];
                end
            endcase
        end

        // collect a suffix character
        if (p_sfx) begin
            if (p_slen == 2'd3) begin
                p_err = 1'b1;
            end else begin
                p_suf  = {p_suf[15:0], lower_c};
                p_slen = p_slen + 2'd1;
            end
        end
    end

    // Type and value of a finished literal
    always_comb begin
        sfx_hit = ilp_pkg::suffix_type(fin_suf_reg, fin_slen_reg);
        r_ok    = fin_ok_reg;
        if (fin_slen_reg == 2'd0) begin
            priority if (fin_acc_reg[63:31] == '0) r_type = ilp_pkg::TYPE_I32;
            else if (!fin_acc_reg[63])             r_type = ilp_pkg::TYPE_I64;
            else                                   r_type = ilp_pkg::TYPE_U64;
        end else begin
            r_type = sfx_hit[2:0];
            r_ok   = fin_ok_reg && sfx_hit[3];
        end
        r_val = fin_neg_reg ? (64'd0 - fin_acc_reg) : fin_acc_reg;
        unique case (r_type[2:1])
            2'd0:    r_bits = {56'd0, r_val[7:0]};
            2'd1:    r_bits = {48'd0, r_val[15:0]};
            2'd2:    r_bits = {32'd0, r_val[31:0]};
            default: r_bits = r_val;
        endcase
        if (!r_ok) begin
            r_type = ilp_pkg::TYPE_I8;
            r_bits = '0;
        end
    end

    // Next-state selection for all stages
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_char_next   = in_char_reg;
        in_last_next   = in_last_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        suf_next       = suf_reg;
        slen_next      = slen_reg;
        fin_valid_next = fin_valid_reg;
        fin_ok_next    = fin_ok_reg;
        fin_neg_next   = fin_neg_reg;
        fin_acc_next   = fin_acc_reg;
        fin_suf_next   = fin_suf_reg;
        fin_slen_next  = fin_slen_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_type_next  = out_type_reg;
        out_bits_next  = out_bits_reg;

        // input stage
        if (in_ready) begin
            in_valid_next = s_axis_tvalid;
            if (s_axis_tvalid) begin
                in_char_next = s_axis_tdata;
                in_last_next = s_axis_tlast;
            end
        end

        // output stage
        if (out_ready) begin
            out_valid_next = fin_valid_reg;
            if (fin_valid_reg) begin
                out_ok_next   = r_ok;
                out_type_next = r_type;
                out_bits_next = r_bits;
            end
            fin_valid_next = 1'b0;
        end

        // parse stage
        if (in_proc) begin
            if (in_last_reg) begin
                fin_valid_next = 1'b1;
                fin_ok_next    = !p_err &&
                                 (p_phase == PH_ZERO || p_phase == PH_DIG || p_phase == PH_SUF);
                fin_neg_next   = p_neg;
                fin_acc_next   = p_acc;
                fin_suf_next   = p_suf;
                fin_slen_next  = p_slen;
                phase_next     = PH_START;
                neg_next       = 1'b0;
                base_next      = ilp_pkg::BASE_DEC;
                cnt_next       = '0;
                acc_next       = '0;
                err_next       = 1'b0;
                suf_next       = '0;
                slen_next      = 2'd0;
            end else begin
                phase_next = p_phase;
                neg_next   = p_neg;
                base_next  = p_base;
                cnt_next   = p_cnt;
                acc_next   = p_acc;
                err_next   = p_err;
                suf_next   = p_suf;
                slen_next  = p_slen;
            end
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            base_reg      <= ilp_pkg::BASE_DEC;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            suf_reg       <= '0;
            slen_reg      <= 2'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            suf_reg       <= suf_next;
            slen_reg      <= slen_next;
        end
        in_char_reg  <= in_char_next;
        in_last_reg  <= in_last_next;
        fin_ok_reg   <= fin_ok_next;
        fin_neg_reg  <= fin_neg_next;
        fin_acc_reg  <= fin_acc_next;
        fin_suf_reg  <= fin_suf_next;
        fin_slen_reg <= fin_slen_next;
        out_ok_reg   <= out_ok_next;
        out_type_reg <= out_type_next;
        out_bits_reg <= out_bits_next;
    end

    // Outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {5'd0, out_bits_reg, out_type_reg};

`ifndef SYNTHESIS
    // A failed literal reports zero type and value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("failed parse with nonzero payload");

    // A finished literal is held while the output stage is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid_reg && !out_ready) |=> (fin_valid_reg && $stable(fin_acc_reg)))
        else $error("finish register lost while stalled");

    // Start of a literal always carries cleared parse state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START) |-> (acc_reg == '0 && cnt_reg == '0 && !err_reg &&
                                     slen_reg == 2'd0 && !neg_reg))
        else $error("stale state at start of literal");

    // Input side only stalls behind a held character
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && fin_valid_reg))
        else $error("input stalled without a pending last character");
`endif

endmodule
